### rtl/tcf_pkg.sv
// Shared types, widths and codes for the touch panel coordinate filter.
package tcf_pkg;

	localparam int SAMPLES  = 10;
	localparam int SMP_W    = 10;
	localparam int SPAN_W   = 8;
	localparam int SUM_W    = 14;
	localparam int CNT_W    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;
	localparam int DIV_N_W  = SMP_W + SPAN_W;
	localparam int DIV_D_W  = SMP_W;
	localparam int DIV_C_W  = $clog2(DIV_N_W + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_X_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY  = 3'd6;

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_MAP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

endpackage

### rtl/touch_panel_coordinate_filter.sv
// Top level: averages touch conversions per axis and maps them to panel coordinates.
// Conversion transactions are taken one per cycle while idle; after the last one of a group s_axis_tready
// stays low through the average and the calibration quotient in the shared bit-serial divider,
// a multiply state and a finish state (no quotient when the mapped value is forced to zero);
// a y group then holds until the output register frees. arst_n clears control state, loads
// calibration defaults.
module touch_panel_coordinate_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	// conversion input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [9:0] sample
	input  logic                              s_axis_tuser,  // [0] axis (0 x, 1 y)
	// frame output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [15:0]                       m_axis_tdata,  // [7:0] x_pos, [15:8] y_pos
	output logic                              m_axis_tuser,  // [0] notify
	// configuration writes
	input  logic                              cfg_we,
	input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcf_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int SW = tcf_pkg::SMP_W;
	localparam int PW = tcf_pkg::SPAN_W;
	localparam int NW = tcf_pkg::DIV_N_W;

	// calibration registers
	logic [SW-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [PW-1:0] x_span_q, y_span_q;
	logic          notify_always_q;

	// accumulation and frame state
	logic [tcf_pkg::SUM_W-1:0] sum_q;
	logic [tcf_pkg::CNT_W-1:0] cnt_q;
	logic                      axis_q;
	logic [PW-1:0]             pend_x_q;
	logic [PW-1:0]             prev_x_q;
	logic [PW-1:0]             prev_y_q;
	logic [SW-1:0]             avg_q;
	logic [PW-1:0]             coord_q;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] out_x_q;
	logic [PW-1:0] out_y_q;
	logic          out_notify_q;

	tcf_pkg::state_t   state_q, state_d;
	tcf_pkg::div_req_t div_req;
	tcf_pkg::div_rsp_t div_rsp;

	logic                      in_take;
	logic                      in_match;
	logic [tcf_pkg::SUM_W-1:0] sum_nxt;
	logic [tcf_pkg::CNT_W-1:0] cnt_nxt;
	logic                      group_done;

	logic [SW-1:0] sel_low, sel_high;
	logic [PW-1:0] sel_span;
	logic          map_zero;
	logic [SW-1:0] avg_off;
	logic [NW-1:0] product;
	logic [PW-1:0] mapped_sat;
	logic          out_free;
	logic          emit;

	// configuration port; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q         <= SW'(215);
			x_high_q        <= SW'(830);
			y_low_q         <= SW'(400);
			y_high_q        <= SW'(815);
			x_span_q        <= PW'(160);
			y_span_q        <= PW'(104);
			notify_always_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcf_pkg::CFG_X_LOW:  x_low_q         <= cfg_data;
				tcf_pkg::CFG_X_HIGH: x_high_q        <= cfg_data;
				tcf_pkg::CFG_Y_LOW:  y_low_q         <= cfg_data;
				tcf_pkg::CFG_Y_HIGH: y_high_q        <= cfg_data;
				tcf_pkg::CFG_X_SPAN: x_span_q        <= cfg_data[PW-1:0];
				tcf_pkg::CFG_Y_SPAN: y_span_q        <= cfg_data[PW-1:0];
				tcf_pkg::CFG_NOTIFY: notify_always_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input side: a conversion for the other axis is swallowed without effect
	assign s_axis_tready = (state_q == tcf_pkg::ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign in_match      = in_take && (s_axis_tuser == axis_q);
	assign sum_nxt       = sum_q + tcf_pkg::SUM_W'(s_axis_tdata[SW-1:0]);
	assign cnt_nxt       = cnt_q + 1'b1;
	assign group_done    = in_match && (cnt_nxt == tcf_pkg::CNT_W'(tcf_pkg::SAMPLES));

	// limits of the axis being reduced
	assign sel_low  = (axis_q == tcf_pkg::AXIS_Y) ? y_low_q  : x_low_q;
	assign sel_high = (axis_q == tcf_pkg::AXIS_Y) ? y_high_q : x_high_q;
	assign sel_span = (axis_q == tcf_pkg::AXIS_Y) ? y_span_q : x_span_q;

	assign map_zero = (sel_high <= sel_low) || (avg_q < sel_low);
	assign avg_off  = avg_q - sel_low;
	assign product  = NW'(avg_off) * NW'(sel_span);

	// mapped value saturates at the span before the inversion
	assign mapped_sat = (div_rsp.quotient > NW'(sel_span)) ? sel_span
	                                                       : div_rsp.quotient[PW-1:0];

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = NW'(sum_nxt);
		div_req.divisor  = tcf_pkg::DIV_D_W'(tcf_pkg::SAMPLES);
		emit             = 1'b0;
		unique case (state_q)
			tcf_pkg::ST_IDLE: begin
				if (group_done) begin
					div_req.start = 1'b1;
					state_d       = tcf_pkg::ST_AVG;
				end
			end
			tcf_pkg::ST_AVG: begin
				if (div_rsp.done) begin
					state_d = tcf_pkg::ST_MUL;
				end
			end
			tcf_pkg::ST_MUL: begin
				div_req.dividend = product;
				div_req.divisor  = sel_high - sel_low;
				if (map_zero) begin
					state_d = tcf_pkg::ST_FIN;
				end else begin
					div_req.start = 1'b1;
					state_d       = tcf_pkg::ST_MAP;
				end
			end
			tcf_pkg::ST_MAP: begin
				if (div_rsp.done) begin
					state_d = tcf_pkg::ST_FIN;
				end
			end
			tcf_pkg::ST_FIN: begin
				if (axis_q == tcf_pkg::AXIS_X) begin
					state_d = tcf_pkg::ST_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = tcf_pkg::ST_IDLE;
				end
			end
			default: state_d = tcf_pkg::ST_IDLE;
		endcase
	end

	tcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			axis_q   <= tcf_pkg::AXIS_X;
			pend_x_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (in_match) begin
				sum_q <= group_done ? '0 : sum_nxt;
				cnt_q <= group_done ? '0 : cnt_nxt;
			end
			if (state_q == tcf_pkg::ST_FIN && axis_q == tcf_pkg::AXIS_X) begin
				pend_x_q <= coord_q;
				axis_q   <= tcf_pkg::AXIS_Y;
			end
			if (emit) begin
				prev_x_q <= pend_x_q;
				prev_y_q <= coord_q;
				axis_q   <= tcf_pkg::AXIS_X;
			end
		end
	end

	// reduction datapath
	always_ff @(posedge clk) begin
		if (state_q == tcf_pkg::ST_AVG && div_rsp.done) begin
			avg_q <= div_rsp.quotient[SW-1:0];
		end
		if (state_q == tcf_pkg::ST_MUL && map_zero) begin
			coord_q <= sel_span;
		end else if (state_q == tcf_pkg::ST_MAP && div_rsp.done) begin
			coord_q <= sel_span - mapped_sat;
		end
	end

	// output register: holds a frame while the next conversions stream in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q      <= pend_x_q;
			out_y_q      <= coord_q;
			out_notify_q <= (pend_x_q != prev_x_q) || (coord_q != prev_y_q) || notify_always_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q};
	assign m_axis_tuser  = out_notify_q;

endmodule

### rtl/tcf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tcf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tcf_pkg::div_req_t req,
	output tcf_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [tcf_pkg::DIV_C_W-1:0] cnt_q;
	logic [tcf_pkg::DIV_D_W-1:0] rem_q;
	logic [tcf_pkg::DIV_D_W-1:0] dvs_q;
	logic [tcf_pkg::DIV_N_W-1:0] quo_q;

	logic [tcf_pkg::DIV_D_W:0]   trial;
	logic [tcf_pkg::DIV_D_W:0]   diff;
	logic                        qbit;

	// remainder stays below the divisor, so the shifted trial fits one extra bit
	assign trial = {rem_q, quo_q[tcf_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tcf_pkg::DIV_C_W'(tcf_pkg::DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcf_pkg::DIV_C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[tcf_pkg::DIV_D_W-1:0] : trial[tcf_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[tcf_pkg::DIV_N_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### verif/touch_panel_coordinate_filter_tb.sv
// Self-checking testbench for the touch panel coordinate filter.
`timescale 1ns / 100ps

module touch_panel_coordinate_filter_tb;
	import tcf_pkg::*;

	// Longest wait after the last transaction before the block is surely idle: one group
	// reduction, with margin.
	localparam int SETTLE_CYCLES = 64;
	// Run limit: roughly 1800 items at the slowest idle mix, plus the long hold-off and the
	// settle time of every phase, taken several times over.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 800;
	localparam int PHASE_ITEMS   = 225;
	localparam int PHASES        = 7;
	localparam int REPORT_MAX    = 10;
	// Register index past the end of the map; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

	typedef struct {
		logic [SPAN_W-1:0] x_pos;
		logic [SPAN_W-1:0] y_pos;
		logic              notify;
	} frame_t;

	// Tracks calibration registers and group state, predicts each frame and checks it.
	class coord_scoreboard;
		logic [SMP_W-1:0]  x_low, x_high, y_low, y_high;
		logic [SPAN_W-1:0] x_span, y_span;
		logic              notify_always;
		logic [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]  count;
		logic              axis_now;
		logic [SPAN_W-1:0] pending_x, prev_x, prev_y;
		frame_t            frames_due[$];
		int                errors;

		function new();
			x_low = SMP_W'(215);
			x_high = SMP_W'(830);
			y_low = SMP_W'(400);
			y_high = SMP_W'(815);
			x_span = SPAN_W'(160);
			y_span = SPAN_W'(104);
			notify_always = 1'b0;
			sum = '0;
			count = '0;
			axis_now = AXIS_X;
			pending_x = '0;
			prev_x = '0;
			prev_y = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
			case (idx)
				CFG_X_LOW:  x_low = value;
				CFG_X_HIGH: x_high = value;
				CFG_Y_LOW:  y_low = value;
				CFG_Y_HIGH: y_high = value;
				CFG_X_SPAN: x_span = value[SPAN_W-1:0];
				CFG_Y_SPAN: y_span = value[SPAN_W-1:0];
				CFG_NOTIFY: notify_always = value[0];
				default: ;
			endcase
		endfunction

		// Linear map between the limits, clipped to the span, then inverted.
		function logic [SPAN_W-1:0] calibrate(int unsigned avg, int unsigned low,
				int unsigned high, int unsigned span);
			int unsigned scaled;
			scaled = 0;
			if (high > low && avg >= low) begin
				scaled = (avg - low) * span / (high - low);
				if (scaled > span)
					scaled = span;
			end
			return SPAN_W'(span - scaled);
		endfunction

		function void take_conversion(logic axis, logic [SMP_W-1:0] sample);
			int unsigned       avg;
			logic [SPAN_W-1:0] y;
			frame_t            f;
			// conversions for the other axis are dropped
			if (axis != axis_now)
				return;
			sum = sum + sample;
			count = count + 1'b1;
			if (count < SAMPLES)
				return;
			avg = sum / SAMPLES;
			sum = '0;
			count = '0;
			if (axis_now == AXIS_X) begin
				pending_x = calibrate(avg, x_low, x_high, x_span);
				axis_now = AXIS_Y;
				return;
			end
			y = calibrate(avg, y_low, y_high, y_span);
			axis_now = AXIS_X;
			f.x_pos = pending_x;
			f.y_pos = y;
			f.notify = (pending_x != prev_x) || (y != prev_y) || notify_always;
			prev_x = pending_x;
			prev_y = y;
			frames_due.push_back(f);
		endfunction

		function void check_frame(logic [SPAN_W-1:0] x, logic [SPAN_W-1:0] y, logic notify);
			frame_t want;
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected frame: x_pos=%0d y_pos=%0d notify=%0b", x, y, notify);
				return;
			end
			want = frames_due.pop_front();
			if (want.x_pos !== x || want.y_pos !== y || want.notify !== notify) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$write("frame mismatch: expected x_pos=%0d y_pos=%0d notify=%0b,",
						want.x_pos, want.y_pos, want.notify);
					$display(" got x_pos=%0d y_pos=%0d notify=%0b", x, y, notify);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;  // [9:0] sample
	logic                 s_axis_tuser = 1'b0; // [0] axis
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;       // [7:0] x_pos, [15:8] y_pos
	logic                 m_axis_tuser;       // [0] notify
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	coord_scoreboard sb = new();

	// Idle percentages per side, and the one-shot request for a long receiver hold-off.
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_request = 1'b0;
	int  cycles = 0;

	// Sender's own view of the grouping, so that a group can be completed after noise.
	logic seq_axis = AXIS_X;
	int   seq_count = 0;
	int   useful_items = 0;
	int   last_level[2] = '{0, 0};

	touch_panel_coordinate_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Monitor: values sampled here are the ones from before the edge, so every transaction
	// is seen exactly as the block saw it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.take_conversion(s_axis_tuser, s_axis_tdata[SMP_W-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_frame(m_axis_tdata[SPAN_W-1:0], m_axis_tdata[2*SPAN_W-1:SPAN_W],
					m_axis_tuser);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// Frame receiver: random back-pressure, or one long hold-off when requested so that the
	// output fills and the block has to stall its conversion input.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// One conversion transaction, with an optional idle gap in front of it.
	task automatic send_conversion(logic axis, logic [SMP_W-1:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(16 - SMP_W){1'b0}}, sample};
		s_axis_tuser <= axis;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (axis == seq_axis) begin
			useful_items++;
			seq_count++;
			if (seq_count == SAMPLES) begin
				seq_count = 0;
				seq_axis = ~seq_axis;
			end
		end
	endtask

	// Finish the group now being gathered. The level lands near a limit, at an extreme, at
	// random, or repeats the last one exactly so that unchanged frames show up.
	task automatic send_group();
		logic axis;
		int   level, jitter, lo, hi, s;
		axis = seq_axis;
		lo = (axis == AXIS_Y) ? sb.y_low : sb.x_low;
		hi = (axis == AXIS_Y) ? sb.y_high : sb.x_high;
		jitter = $urandom_range(24);
		case ($urandom_range(5))
			0: level = $urandom_range(1023);
			1: level = lo + $urandom_range(16) - 8;
			2: level = hi + $urandom_range(16) - 8;
			3: level = $urandom_range(1) ? 1023 : 0;
			default: begin
				level = last_level[axis];
				jitter = 0;
			end
		endcase
		last_level[axis] = level;
		while (seq_axis == axis) begin
			if ($urandom_range(11) == 0)
				send_conversion(~axis, SMP_W'($urandom_range(1023)));
			s = level + $urandom_range(2 * jitter) - jitter;
			if (s < 0)
				s = 0;
			if (s > 1023)
				s = 1023;
			send_conversion(axis, SMP_W'(s));
		end
	endtask

	// One write transaction; the enable drops again after each write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Calibration for each phase: moderate, full range, degenerate limits (high not above
	// low), one-code windows, random, defaults, random.
	task automatic configure(int phase);
		logic [CFG_DAT_W-1:0] vals[7];
		int                   i;
		case (phase)
			0: vals = '{100, 900, 50, 1000, 200, 128, 0};
			1: vals = '{0, 1023, 0, 1023, 255, 255, 1};
			2: vals = '{600, 600, 1023, 0, 1, 1, 0};
			3: vals = '{1022, 1023, 0, 1, 255, 1, 0};
			5: vals = '{215, 830, 400, 815, 160, 104, 0};
			default: begin
				for (i = 0; i < 7; i++)
					vals[i] = CFG_DAT_W'($urandom_range(1023));
			end
		endcase
		for (i = CFG_X_LOW; i <= CFG_NOTIFY; i++)
			write_reg(CFG_IDX_W'(i), vals[i]);
		write_reg(CFG_NONE, CFG_DAT_W'($urandom_range(1023)));
	endtask

	// Stop offering, let every expected frame arrive, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase, goal, i;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 82;

		// Directed frame at reset calibration: x group at full scale (saturates, x_pos 0)
		// with a stray y conversion, y group at zero (below the low limit, y_pos is the span)
		// with a stray x conversion.
		for (i = 0; i < SAMPLES; i++) begin
			if (i == 4)
				send_conversion(AXIS_Y, '0);
			send_conversion(AXIS_X, '1);
		end
		for (i = 0; i < SAMPLES; i++) begin
			if (i == 6)
				send_conversion(AXIS_X, '1);
			send_conversion(AXIS_Y, '0);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			configure(phase);
			if (phase < 2) begin
				send_idle_pct = 20;
				recv_idle_pct = 82;
			end else if (phase < 4) begin
				send_idle_pct = 82;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase == 5)
				hold_request = 1'b1;
			goal = useful_items + PHASE_ITEMS;
			while (useful_items < goal) begin
				// mostly complete groups; now and then a ragged burst of either axis
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 6))
						send_conversion(1'($urandom_range(1)),
							SMP_W'($urandom_range(1023)));
				else
					send_group();
			end
		end

		drain();
		if (sb.errors == 0 && sb.frames_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
